@@ sv/fie_pkg.sv @@
// ----------------------------------------------------------------------------
// fie_pkg
// Shared constants and types of the frame interval estimator.
// ----------------------------------------------------------------------------
`default_nettype none

package fie_pkg;

	localparam int WINDOW    = 100;
	localparam int TS_W      = 63;
	localparam int TIMEOUT_W = 32;
	localparam int IDX_W     = (WINDOW > 1) ? $clog2(WINDOW) : 1;
	localparam int CNT_W     = $clog2(WINDOW + 1);
	// exact window sum, never wraps
	localparam int SUM_W     = TS_W + CNT_W;
	localparam int ITER_W    = $clog2(TS_W);

	localparam logic [TIMEOUT_W-1:0] TIMEOUT_RST = TIMEOUT_W'(100000000);

	localparam logic OP_DAMAGE = 1'b0;
	localparam logic OP_QUERY  = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ADD,
		ST_SUB,
		ST_DIV_GO,
		ST_DIV_WAIT,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic                 start;
		logic [TS_W-1:0]      dividend;
		logic [CNT_W-1:0]     divisor;
	} div_req_t;

	typedef struct packed {
		logic                 done;
		logic [TS_W-1:0]      quotient;
	} div_rsp_t;

endpackage

`default_nettype wire

@@ sv/frame_interval_estimator_unit.sv @@
// ----------------------------------------------------------------------------
// frame_interval_estimator_unit
// Moving-average frame period estimate from damage timestamps, with staleness.
// ----------------------------------------------------------------------------
// query item, or first damage: result goes to the output register from ST_EMIT once the output is free
// damage item: ring read, sum add, sum subtract, then the bit-serial divide
// one item at a time; the next item is taken while a result waits for out_stall
// throughput set by the bit-serial divider: one quotient bit per cycle
// reset clears all control state, timeout resets to 100 ms; ring needs no clear
`default_nettype none

module frame_interval_estimator_unit (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            in_valid,
	output      logic                            in_stall,
	input  wire logic                            operation,
	input  wire logic [fie_pkg::TS_W-1:0]        timestamp_ns,
	output      logic                            out_valid,
	input  wire logic                            out_stall,
	output      logic                            estimate_valid,
	output      logic [fie_pkg::TS_W-1:0]        estimate_ns,
	input  wire logic                            cfg_we,
	input  wire logic [fie_pkg::TIMEOUT_W-1:0]   cfg_wdata
);

	fie_pkg::state_t                  state_q;
	fie_pkg::state_t                  state_d;

	logic [fie_pkg::TIMEOUT_W-1:0]    timeout_q;
	logic [fie_pkg::IDX_W-1:0]        head_q;
	logic [fie_pkg::CNT_W-1:0]        cnt_q;
	logic [fie_pkg::SUM_W-1:0]        sum_q;
	logic [fie_pkg::TS_W-1:0]         last_q;
	logic                             seen_q;
	logic [fie_pkg::TS_W-1:0]         mean_q;
	logic                             mean_valid_q;
	logic [fie_pkg::TS_W-1:0]         iv_q;
	logic                             drop_q;
	logic                             res_valid_q;
	logic [fie_pkg::TS_W-1:0]         res_est_q;
	logic                             out_valid_q;
	logic                             est_valid_q;
	logic [fie_pkg::TS_W-1:0]         est_q;

	logic                             accept;
	logic                             slot_free;
	logic                             ram_re;
	logic                             ram_we;
	logic                             emit;
	logic                             div_start;
	logic [fie_pkg::TS_W-1:0]         old_iv;
	logic [fie_pkg::TS_W:0]           diff;
	logic                             stale;
	logic [fie_pkg::TS_W-1:0]         sum_sat;
	fie_pkg::div_req_t                div_req;
	fie_pkg::div_rsp_t                div_rsp;

	fie_ram #(
		.WIDTH(fie_pkg::TS_W),
		.DEPTH(fie_pkg::WINDOW)
	) u_ring (
		.clk   (clk),
		.we    (ram_we),
		.waddr (head_q),
		.wdata (iv_q),
		.re    (ram_re),
		.raddr (head_q),
		.rdata (old_iv)
	);

	fie_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	assign accept    = in_valid && !in_stall;
	assign slot_free = !out_valid_q || !out_stall;

	// age of the event against the last damage, borrow in the top bit
	assign diff  = {1'b0, timestamp_ns} - {1'b0, last_q};
	assign stale = seen_q && !diff[fie_pkg::TS_W] &&
		(diff[fie_pkg::TS_W-1:0] >
		 {{(fie_pkg::TS_W - fie_pkg::TIMEOUT_W){1'b0}}, timeout_q});

	assign sum_sat = (|sum_q[fie_pkg::SUM_W-1:fie_pkg::TS_W]) ? {fie_pkg::TS_W{1'b1}}
		: sum_q[fie_pkg::TS_W-1:0];

	assign div_req = '{start: div_start, dividend: sum_sat, divisor: cnt_q};

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			fie_pkg::ST_IDLE: begin
				if (accept) begin
					if (operation == fie_pkg::OP_DAMAGE && seen_q) begin
						state_d = fie_pkg::ST_ADD;
					end else begin
						state_d = fie_pkg::ST_EMIT;
					end
				end
			end
			fie_pkg::ST_ADD:      state_d = fie_pkg::ST_SUB;
			fie_pkg::ST_SUB:      state_d = fie_pkg::ST_DIV_GO;
			fie_pkg::ST_DIV_GO:   state_d = fie_pkg::ST_DIV_WAIT;
			fie_pkg::ST_DIV_WAIT: begin
				if (div_rsp.done) begin
					state_d = fie_pkg::ST_EMIT;
				end
			end
			fie_pkg::ST_EMIT: begin
				if (slot_free) begin
					state_d = fie_pkg::ST_IDLE;
				end
			end
			default: state_d = fie_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		in_stall  = 1'b1;
		ram_re    = 1'b0;
		ram_we    = 1'b0;
		div_start = 1'b0;
		emit      = 1'b0;
		unique case (state_q)
			fie_pkg::ST_IDLE: begin
				in_stall = 1'b0;
				ram_re   = in_valid && operation == fie_pkg::OP_DAMAGE;
			end
			fie_pkg::ST_ADD:      ram_we    = 1'b1;
			fie_pkg::ST_SUB:      ;
			fie_pkg::ST_DIV_GO:   div_start = 1'b1;
			fie_pkg::ST_DIV_WAIT: ;
			fie_pkg::ST_EMIT:     emit      = slot_free;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= fie_pkg::ST_IDLE;
			timeout_q    <= fie_pkg::TIMEOUT_RST;
			head_q       <= '0;
			cnt_q        <= '0;
			sum_q        <= '0;
			last_q       <= '0;
			seen_q       <= 1'b0;
			mean_q       <= '0;
			mean_valid_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				timeout_q <= cfg_wdata;
			end
			if (accept && operation == fie_pkg::OP_DAMAGE) begin
				last_q <= timestamp_ns;
				seen_q <= 1'b1;
			end
			if (state_q == fie_pkg::ST_ADD) begin
				sum_q  <= sum_q + {{fie_pkg::CNT_W{1'b0}}, iv_q};
				head_q <= (head_q == fie_pkg::IDX_W'(fie_pkg::WINDOW - 1)) ? '0
					: head_q + 1'b1;
				if (cnt_q != fie_pkg::CNT_W'(fie_pkg::WINDOW)) begin
					cnt_q <= cnt_q + 1'b1;
				end
			end
			// the overwritten oldest interval leaves the sum
			if (state_q == fie_pkg::ST_SUB && drop_q) begin
				sum_q <= sum_q - {{fie_pkg::CNT_W{1'b0}}, old_iv};
			end
			if (state_q == fie_pkg::ST_DIV_WAIT && div_rsp.done) begin
				mean_q       <= div_rsp.quotient;
				mean_valid_q <= 1'b1;
			end
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			iv_q <= diff[fie_pkg::TS_W] ? '0 : diff[fie_pkg::TS_W-1:0];
			if (operation == fie_pkg::OP_QUERY) begin
				res_valid_q <= mean_valid_q && !stale;
				res_est_q   <= (mean_valid_q && !stale) ? mean_q : '0;
			end else begin
				res_valid_q <= mean_valid_q;
				res_est_q   <= mean_valid_q ? mean_q : '0;
			end
		end
		if (state_q == fie_pkg::ST_ADD) begin
			drop_q <= (cnt_q == fie_pkg::CNT_W'(fie_pkg::WINDOW));
		end
		if (state_q == fie_pkg::ST_DIV_WAIT && div_rsp.done) begin
			res_valid_q <= 1'b1;
			res_est_q   <= div_rsp.quotient;
		end
		if (emit) begin
			est_valid_q <= res_valid_q;
			est_q       <= res_est_q;
		end
	end

	assign out_valid      = out_valid_q;
	assign estimate_valid = est_valid_q;
	assign estimate_ns    = est_q;

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= fie_pkg::CNT_W'(fie_pkg::WINDOW))
		else $error("interval count beyond window");

	a_head_bound: assert property (@(posedge clk) disable iff (!arst_n)
		head_q < fie_pkg::IDX_W'(fie_pkg::WINDOW - 1) ||
		head_q == fie_pkg::IDX_W'(fie_pkg::WINDOW - 1))
		else $error("ring head out of range");

	a_mean_needs_damage: assert property (@(posedge clk) disable iff (!arst_n)
		mean_valid_q |-> seen_q && cnt_q != '0)
		else $error("estimate without recorded interval");

	a_div_done_state: assert property (@(posedge clk) disable iff (!arst_n)
		div_rsp.done |-> state_q == fie_pkg::ST_DIV_WAIT)
		else $error("divider finished outside of wait");

	a_invalid_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !estimate_valid |-> estimate_ns == '0)
		else $error("invalid estimate carries nonzero value");

endmodule

`default_nettype wire

@@ sv/fie_ram.sv @@
// ----------------------------------------------------------------------------
// fie_ram
// Generic single-port-write, single-port-read RAM with registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module fie_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                                  clk,
	input  wire logic                                  we,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                      wdata,
	input  wire logic                                  re,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output      logic [WIDTH-1:0]                      rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

@@ sv/fie_div.sv @@
// ----------------------------------------------------------------------------
// fie_div
// Bit-serial restoring divider: window sum by interval count, one bit a cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module fie_div (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire fie_pkg::div_req_t req,
	output      fie_pkg::div_rsp_t rsp
);

	logic                                 busy_q;
	logic                                 done_q;
	logic [fie_pkg::ITER_W-1:0]           iter_q;
	logic [fie_pkg::TS_W-1:0]             dq_q;
	logic [fie_pkg::CNT_W-1:0]            rem_q;
	logic [fie_pkg::CNT_W-1:0]            dvs_q;
	logic [fie_pkg::CNT_W:0]              rem_sh;
	logic [fie_pkg::CNT_W:0]              rem_sub;
	logic                                 ge;

	assign rem_sh  = {rem_q, dq_q[fie_pkg::TS_W-1]};
	assign ge      = (rem_sh >= {1'b0, dvs_q});
	assign rem_sub = rem_sh - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			iter_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				iter_q <= fie_pkg::ITER_W'(fie_pkg::TS_W - 1);
			end else if (busy_q) begin
				if (iter_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					iter_q <= iter_q - 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			dq_q  <= req.dividend;
			dvs_q <= req.divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			// quotient bits shift in where dividend bits shift out
			dq_q  <= {dq_q[fie_pkg::TS_W-2:0], ge};
			rem_q <= ge ? rem_sub[fie_pkg::CNT_W-1:0] : rem_sh[fie_pkg::CNT_W-1:0];
		end
	end

	assign rsp.done     = done_q;
	assign rsp.quotient = dq_q;

endmodule

`default_nettype wire

@@ dv/frame_interval_estimator_unit_test.sv @@
// ----------------------------------------------------------------------------
// frame_interval_estimator_unit_test
// Self-checking bench for the frame interval estimator. A short table of
// directed items covers the edge cases and the timeout register limits. Random
// damage and query traffic follows under several timeout values and idle
// patterns. Every result is compared with the table's expected estimate or with
// an in-bench model of the moving average, the saturating window sum and the staleness rule.
// ----------------------------------------------------------------------------
`default_nettype none

module frame_interval_estimator_unit_test;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int WATCHDOG_LIMIT = 5000;
	localparam int HOLD_CYCLES    = 400;
	localparam int PHASES         = 6;
	localparam int PHASE_ITEMS    = 170;
	localparam int DRAIN_CYCLES   = 100;
	localparam logic [fie_pkg::TS_W-1:0] TS_MAX = {fie_pkg::TS_W{1'b1}};

	typedef struct packed {
		logic                     valid;
		logic [fie_pkg::TS_W-1:0] ns;
	} estimate_t;

	typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

	// arg is the timestamp of an item, or the timeout value of a register write
	typedef struct packed {
		row_kind_t                kind;
		logic                     op;
		logic [fie_pkg::TS_W-1:0] arg;
		logic                     typed;
		estimate_t                known;
	} stim_row_t;

	localparam estimate_t NO_ESTIMATE = '{valid: 1'b0, ns: '0};

	stim_row_t directed_rows [21] = '{
		'{ROW_ITEM, fie_pkg::OP_QUERY,  63'd0,          1'b1, NO_ESTIMATE},
		'{ROW_ITEM, fie_pkg::OP_QUERY,  TS_MAX,         1'b1, NO_ESTIMATE},
		// first damage only records its time
		'{ROW_ITEM, fie_pkg::OP_DAMAGE, 63'd0,          1'b1, NO_ESTIMATE},
		'{ROW_ITEM, fie_pkg::OP_DAMAGE, 63'd1000,       1'b1, '{1'b1, 63'd1000}},
		// age equal to the timeout is still fresh, one more ns is stale
		'{ROW_ITEM, fie_pkg::OP_QUERY,  63'd100001000,  1'b1, '{1'b1, 63'd1000}},
		'{ROW_ITEM, fie_pkg::OP_QUERY,  63'd100001001,  1'b1, NO_ESTIMATE},
		// query from before the last damage is never stale
		'{ROW_ITEM, fie_pkg::OP_QUERY,  63'd500,        1'b1, '{1'b1, 63'd1000}},
		// time going backwards gives a zero interval
		'{ROW_ITEM, fie_pkg::OP_DAMAGE, 63'd500,        1'b1, '{1'b1, 63'd500}},
		// huge interval saturates the window sum
		'{ROW_ITEM, fie_pkg::OP_DAMAGE, TS_MAX,         1'b0, NO_ESTIMATE},
		'{ROW_ITEM, fie_pkg::OP_QUERY,  63'd0,          1'b0, NO_ESTIMATE},
		'{ROW_ITEM, fie_pkg::OP_DAMAGE, TS_MAX,         1'b0, NO_ESTIMATE},
		'{ROW_CFG,  fie_pkg::OP_QUERY,  63'd0,          1'b0, NO_ESTIMATE},
		'{ROW_ITEM, fie_pkg::OP_DAMAGE, 63'd5000,       1'b0, NO_ESTIMATE},
		'{ROW_ITEM, fie_pkg::OP_QUERY,  63'd5000,       1'b0, NO_ESTIMATE},
		'{ROW_ITEM, fie_pkg::OP_QUERY,  63'd5001,       1'b1, NO_ESTIMATE},
		'{ROW_CFG,  fie_pkg::OP_QUERY,  63'hFFFFFFFF,   1'b0, NO_ESTIMATE},
		'{ROW_ITEM, fie_pkg::OP_QUERY,  63'd4294972295, 1'b0, NO_ESTIMATE},
		'{ROW_ITEM, fie_pkg::OP_QUERY,  63'd4294972296, 1'b1, NO_ESTIMATE},
		'{ROW_ITEM, fie_pkg::OP_DAMAGE, 63'd4294972296, 1'b0, NO_ESTIMATE},
		'{ROW_CFG,  fie_pkg::OP_QUERY,  63'd100000000,  1'b0, NO_ESTIMATE},
		'{ROW_ITEM, fie_pkg::OP_QUERY,  TS_MAX,         1'b1, NO_ESTIMATE}
	};

	logic                          clk = 1'b0;
	logic                          arst_n = 1'b0;
	logic                          in_valid = 1'b0;
	logic                          in_stall;
	logic                          operation = fie_pkg::OP_QUERY;
	logic [fie_pkg::TS_W-1:0]      timestamp_ns = '0;
	logic                          out_valid;
	logic                          out_stall = 1'b0;
	logic                          estimate_valid;
	logic [fie_pkg::TS_W-1:0]      estimate_ns;
	logic                          cfg_we = 1'b0;
	logic [fie_pkg::TIMEOUT_W-1:0] cfg_wdata = '0;

	// model of the estimator
	logic [fie_pkg::TS_W-1:0]      window_iv [fie_pkg::WINDOW];
	int                            window_head = 0;
	int                            window_fill = 0;
	logic [fie_pkg::TS_W-1:0]      last_damage_ns = '0;
	logic                          damage_seen = 1'b0;
	logic [fie_pkg::TS_W-1:0]      mean_ns = '0;
	logic                          mean_ok = 1'b0;
	logic [fie_pkg::TIMEOUT_W-1:0] stale_ns = fie_pkg::TIMEOUT_RST;

	estimate_t                     pending_estimates [$];
	int                            mismatches = 0;
	int                            idle_cycles = 0;
	int                            sender_idle_pct = 33;
	int                            receiver_idle_pct = 62;
	int                            hold_request = 0;
	int                            hold_left = 0;

	frame_interval_estimator_unit dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.operation     (operation),
		.timestamp_ns  (timestamp_ns),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.estimate_valid(estimate_valid),
		.estimate_ns   (estimate_ns),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata)
	);

	always #10 clk = ~clk;

	function automatic estimate_t step_estimator(input logic op,
		input logic [fie_pkg::TS_W-1:0] ts);
		logic [fie_pkg::SUM_W-1:0] exact_sum;
		int                        slot;
		estimate_t                 est;
		if (op == fie_pkg::OP_DAMAGE) begin
			if (damage_seen) begin
				window_iv[window_head] = (ts >= last_damage_ns) ? ts - last_damage_ns : '0;
				window_head = (window_head + 1 == fie_pkg::WINDOW) ? 0 : window_head + 1;
				if (window_fill < fie_pkg::WINDOW)
					window_fill++;
				exact_sum = '0;
				slot = window_head;
				for (int i = 0; i < window_fill; i++) begin
					slot = (slot == 0) ? fie_pkg::WINDOW - 1 : slot - 1;
					exact_sum += window_iv[slot];
				end
				// sum saturates at the top of the timestamp range
				mean_ns = ((exact_sum > TS_MAX) ? TS_MAX : exact_sum[fie_pkg::TS_W-1:0]) /
					fie_pkg::TS_W'(window_fill);
				mean_ok = 1'b1;
			end
			last_damage_ns = ts;
			damage_seen = 1'b1;
		end
		est.valid = mean_ok && !(damage_seen && ts > last_damage_ns &&
			ts - last_damage_ns > fie_pkg::TS_W'(stale_ns));
		est.ns = est.valid ? mean_ns : '0;
		return est;
	endfunction

	task automatic flag_mismatch(input string what, input logic [fie_pkg::TS_W-1:0] got,
		input logic [fie_pkg::TS_W-1:0] want);
		$display("mismatch %s: got %0d expected %0d", what, got, want);
		mismatches++;
	endtask

	task automatic offer_item(input logic op, input logic [fie_pkg::TS_W-1:0] ts,
		input logic typed, input estimate_t known);
		estimate_t predicted;
		while ($urandom_range(99) < sender_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		operation <= op;
		timestamp_ns <= ts;
		@(posedge clk);
		while (in_stall !== 1'b0)
			@(posedge clk);
		predicted = step_estimator(op, ts);
		pending_estimates.insert(pending_estimates.size(), typed ? known : predicted);
		@(negedge clk);
	endtask

	task automatic set_stale_timeout(input logic [fie_pkg::TIMEOUT_W-1:0] value);
		in_valid <= 1'b0;
		while (pending_estimates.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		@(negedge clk);
		cfg_we <= 1'b0;
		stale_ns = value;
	endtask

	// receiver: random stalls, plus one long hold-off on request
	always @(negedge clk) begin
		if (hold_request != 0) begin
			hold_left = hold_request;
			hold_request = 0;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(99) < receiver_idle_pct);
		end
	end

	always @(posedge clk) begin
		estimate_t want;
		if (arst_n && out_valid === 1'b1 && out_stall == 1'b0) begin
			if (pending_estimates.size() == 0) begin
				flag_mismatch("result with nothing expected", estimate_ns, '0);
			end else begin
				want = pending_estimates[0];
				pending_estimates.delete(0);
				if (estimate_valid !== want.valid)
					flag_mismatch("estimate_valid", fie_pkg::TS_W'(estimate_valid),
						fie_pkg::TS_W'(want.valid));
				if (estimate_ns !== want.ns)
					flag_mismatch("estimate_ns", estimate_ns, want.ns);
			end
		end
		if ((in_valid && in_stall === 1'b0) || (out_valid === 1'b1 && !out_stall))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("timeout: no item moved for %0d cycles", WATCHDOG_LIMIT);
			$display("FAIL frame_interval_estimator_unit");
			$finish;
		end
	end

	initial begin
		int                            p;
		int                            pick;
		logic                          op;
		logic [fie_pkg::TS_W-1:0]      ts;
		logic [fie_pkg::TS_W-1:0]      now_ns;
		logic [fie_pkg::TS_W-1:0]      age;
		logic [fie_pkg::TIMEOUT_W-1:0] tmo;

		now_ns = '0;
		repeat (12) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		for (int i = 0; i < $size(directed_rows); i++) begin
			if (directed_rows[i].kind == ROW_CFG)
				set_stale_timeout(directed_rows[i].arg[fie_pkg::TIMEOUT_W-1:0]);
			else
				offer_item(directed_rows[i].op, directed_rows[i].arg, directed_rows[i].typed,
					directed_rows[i].known);
		end
		now_ns = 63'd4294972296;

		for (p = 0; p < PHASES; p++) begin
			case (p / 2)
				0: begin
					sender_idle_pct = 33;
					receiver_idle_pct = 62;
				end
				1: begin
					sender_idle_pct = 62;
					receiver_idle_pct = 33;
				end
				default: begin
					sender_idle_pct = 0;
					receiver_idle_pct = 0;
				end
			endcase
			case (p)
				0: tmo = 50000000;
				1: tmo = '0;
				2: tmo = '1;
				3: tmo = $urandom;
				4: tmo = fie_pkg::TIMEOUT_RST;
				default: tmo = $urandom_range(40000000, 1);
			endcase
			set_stale_timeout(tmo);
			// fill the block while the output is held off
			if (p == 0)
				hold_request = HOLD_CYCLES;

			for (int n = 0; n < PHASE_ITEMS; n++) begin
				pick = $urandom_range(99);
				op = fie_pkg::OP_DAMAGE;
				if (pick < 55) begin
					now_ns = now_ns + fie_pkg::TS_W'($urandom_range(33333334, 1));
					ts = now_ns;
				end else if (pick < 80) begin
					op = fie_pkg::OP_QUERY;
					case ($urandom_range(2))
						// right around the stale threshold
						0: age = fie_pkg::TS_W'(stale_ns) +
							fie_pkg::TS_W'(longint'($urandom_range(4)) - 2);
						1: age = fie_pkg::TS_W'($urandom);
						default: age = fie_pkg::TS_W'({$urandom, $urandom});
					endcase
					ts = now_ns + age;
				end else if (pick < 88) begin
					now_ns = now_ns - fie_pkg::TS_W'($urandom_range(50000000));
					ts = now_ns;
				end else if (pick < 94) begin
					op = $urandom_range(1) ? fie_pkg::OP_QUERY : fie_pkg::OP_DAMAGE;
					now_ns = fie_pkg::TS_W'({$urandom, $urandom});
					ts = now_ns;
				end else begin
					// large jump that can push the window sum into saturation
					now_ns = now_ns + (fie_pkg::TS_W'({$urandom, $urandom}) >> 1);
					ts = now_ns;
				end
				offer_item(op, ts, 1'b0, NO_ESTIMATE);
			end
		end

		in_valid <= 1'b0;
		while (pending_estimates.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (mismatches == 0)
			$display("PASS frame_interval_estimator_unit");
		else
			$display("FAIL frame_interval_estimator_unit");
		$finish;
	end

endmodule

`default_nettype wire

@@ files.f @@
sv/fie_pkg.sv
sv/fie_ram.sv
sv/fie_div.sv
sv/frame_interval_estimator_unit.sv
dv/frame_interval_estimator_unit_test.sv
